// File: design/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants for the three-cluster k-means block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int NCLU = 3;
  localparam int NFEAT = 4;
  localparam int DIST_W = 68;

  localparam logic [1:0] METRIC_EUCLID = 2'd0;
  localparam logic [1:0] METRIC_SQDIFF = 2'd1;
  localparam logic [1:0] METRIC_MANH = 2'd2;

  localparam logic [2:0] CFG_METRIC = 3'd0;
  localparam logic [2:0] CFG_SEED0 = 3'd1;
  localparam logic [2:0] CFG_SEED1 = 3'd2;
  localparam logic [2:0] CFG_SEED2 = 3'd3;
  localparam logic [2:0] CFG_LIMIT = 3'd4;

  typedef struct packed {
    logic [15:0] sepal_length;
    logic [15:0] sepal_width;
    logic [15:0] petal_length;
    logic [15:0] petal_width;
    logic last_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic [1:0] cluster;
    logic [7:0] passes_done;
    logic converged;
    logic final_label;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEED, ST_SEEDW, ST_ASSIGN, ST_DRAIN, ST_DIV, ST_DIVW,
    ST_CHECK, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0] metric;
  } lane_ctl_t;

endpackage

// File: design/kmc_lane.sv
// ----------------------------------------------------------------------------
// kmc_lane
// One distance lane: distance from a point to one centroid in three stages.
// ----------------------------------------------------------------------------
module kmc_lane import kmc_pkg::*; #(
  parameter int FEATURE_BITS = 16
) (
  input  logic clk,
  input  lane_ctl_t ctl,
  input  logic [NFEAT*FEATURE_BITS-1:0] pnt,
  input  logic [NFEAT*FEATURE_BITS-1:0] cen,
  output logic [DIST_W-1:0] lane_dist
);

  localparam int SQ_W = 2*FEATURE_BITS;
  logic [SQ_W-1:0] d1_r [NFEAT];
  logic [2*SQ_W-1:0] d2_r [NFEAT];
  logic [DIST_W-1:0] dist_r;
  logic [1:0] m1_r;
  logic [DIST_W-1:0] sum_nxt;

  always_ff @(posedge clk) begin
    m1_r <= ctl.metric;
    for (int f = 0; f < NFEAT; f++) begin
      logic [FEATURE_BITS-1:0] a, b;
      logic [SQ_W-1:0] a2, b2;
      a = pnt[f*FEATURE_BITS +: FEATURE_BITS];
      b = cen[f*FEATURE_BITS +: FEATURE_BITS];
      a2 = a * a;
      b2 = b * b;
      if (ctl.metric == METRIC_SQDIFF) begin
        d1_r[f] <= (a2 > b2) ? a2 - b2 : b2 - a2;
      end else begin
        d1_r[f] <= SQ_W'((a > b) ? a - b : b - a);
      end
    end
    for (int f = 0; f < NFEAT; f++) begin
      if (m1_r == METRIC_EUCLID || m1_r == METRIC_SQDIFF) begin
        d2_r[f] <= d1_r[f] * d1_r[f];
      end else begin
        d2_r[f] <= (2*SQ_W)'(d1_r[f]);
      end
    end
    dist_r <= sum_nxt;
  end

  always_comb begin
    sum_nxt = '0;
    for (int f = 0; f < NFEAT; f++) begin
      sum_nxt = sum_nxt + DIST_W'(d2_r[f]);
    end
  end

  assign lane_dist = dist_r;

endmodule

// File: design/kmc_merge.sv
// ----------------------------------------------------------------------------
// kmc_merge
// Picks the nearest of three lane distances, lowest index winning ties.
// ----------------------------------------------------------------------------
module kmc_merge import kmc_pkg::*; (
  input  logic [DIST_W-1:0] d0,
  input  logic [DIST_W-1:0] d1,
  input  logic [DIST_W-1:0] d2,
  output logic [1:0] label
);

  logic [DIST_W-1:0] best;
  logic [1:0] lab;

  always_comb begin
    best = d0;
    lab = 2'd0;
    if (d1 < best) begin
      best = d1;
      lab = 2'd1;
    end
    if (d2 < best) begin
      lab = 2'd2;
    end
  end

  assign label = lab;

endmodule

// File: design/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kmc_div #(
  parameter int NW = 22,
  parameter int DW = 7
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic busy,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] q_r;
  logic [DW:0] rem_r;
  logic [DW-1:0] den_r;
  logic [$clog2(NW+1)-1:0] cnt_r;
  logic busy_r;
  logic [DW+1:0] trial;

  assign trial = {rem_r, q_r[NW-1]} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == ($clog2(NW+1))'(1)) begin
      busy_r <= 1'b0;
    end
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= ($clog2(NW+1))'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trial[DW+1]) begin
        rem_r <= trial[DW:0];
        q_r <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DW-1:0], q_r[NW-1]};
        q_r <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo = q_r;

endmodule

// File: design/kmeans_three_cluster_top.sv
// ----------------------------------------------------------------------------
// kmeans_three_cluster_top
// Three-cluster Lloyd k-means over up to POINTS four-feature points.
// ----------------------------------------------------------------------------
// Points are stored at one item per cycle. The item that marks the last point
// stalls the input for the whole run: after the seed load, each pass streams
// the stored points through three distance lanes, one point per cycle, and
// drains the lane pipeline, then divides twelve sums one after another on a
// restoring divider with a 22-bit quotient and runs the convergence check.
// The labels then leave one item per cycle while the output is not stalled.
module kmeans_three_cluster_top import kmc_pkg::*; #(
  parameter int POINTS = 64,
  parameter int FEATURE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int PW = NFEAT*FEATURE_BITS;
  localparam int IW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS+1);
  localparam int SW = FEATURE_BITS + IW;
  localparam int LAT = 3;

  logic [1:0] metric_r;
  logic [5:0] seed_r [NCLU];
  logic [7:0] limit_r;

  logic [PW-1:0] mem [POINTS];
  logic [PW-1:0] rd_r;
  logic [1:0] lab_mem [POINTS];
  logic [IW-1:0] rd_addr;

  state_t state_r, state_nxt;
  logic [CW-1:0] load_r, n_r;
  logic [CW-1:0] idx_r;
  logic [7:0] pass_r;
  logic conv_r, same_r;
  logic [PW-1:0] cen_r [NCLU];
  logic [SW-1:0] sum_r [NCLU][NFEAT];
  logic [CW-1:0] cnt_r [NCLU];
  logic [LAT:0] vpipe_r;
  logic [IW-1:0] ipipe_r [LAT+1];
  logic [3:0] dj_r;
  logic [1:0] sk_r;
  logic ovalid_r;
  out_item_t odata_r;

  logic [DIST_W-1:0] lane_dist [NCLU];
  logic [1:0] label;
  lane_ctl_t ctl;
  logic div_start, div_busy;
  logic [SW-1:0] div_num, quo;
  logic [CW-1:0] div_den;

  logic acc, emit_take;
  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign cfg_ready = 1'b1;
  assign emit_take = !ovalid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= METRIC_EUCLID;
      seed_r[0] <= 6'd0;
      seed_r[1] <= 6'd1;
      seed_r[2] <= 6'd2;
      limit_r <= 8'd20;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_METRIC: metric_r <= cfg_data[1:0];
        CFG_SEED0: seed_r[0] <= cfg_data[5:0];
        CFG_SEED1: seed_r[1] <= cfg_data[5:0];
        CFG_SEED2: seed_r[2] <= cfg_data[5:0];
        CFG_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_addr = idx_r[IW-1:0];
    if (state_r == ST_SEED) begin
      rd_addr = (7'(seed_r[sk_r]) >= 7'(n_r)) ? IW'(n_r - 1'b1) : IW'(seed_r[sk_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && load_r < CW'(POINTS)) begin
      mem[load_r[IW-1:0]] <= {in_data.sepal_length[FEATURE_BITS-1:0],
        in_data.sepal_width[FEATURE_BITS-1:0], in_data.petal_length[FEATURE_BITS-1:0],
        in_data.petal_width[FEATURE_BITS-1:0]};
    end
    rd_r <= mem[rd_addr];
    if (vpipe_r[LAT]) begin
      lab_mem[ipipe_r[LAT]] <= label;
    end
  end

  assign ctl.metric = metric_r;

  for (genvar k = 0; k < NCLU; k++) begin : g_lane
    kmc_lane #(.FEATURE_BITS(FEATURE_BITS)) u_lane (
      .clk(clk), .ctl(ctl), .pnt(rd_r), .cen(cen_r[k]), .lane_dist(lane_dist[k])
    );
  end

  kmc_merge u_merge (.d0(lane_dist[0]), .d1(lane_dist[1]), .d2(lane_dist[2]),
    .label(label));

  logic [PW-1:0] pt_pipe_r [LAT];

  always_comb begin
    div_num = sum_r[dj_r[3:2]][dj_r[1:0]];
    div_den = cnt_r[dj_r[3:2]];
  end

  kmc_div #(.NW(SW), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      load_r <= '0;
      vpipe_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vpipe_r <= {vpipe_r[LAT-1:0], state_r == ST_ASSIGN};
      if (acc) begin
        if (in_data.last_point) begin
          load_r <= '0;
        end else if (load_r < CW'(POINTS)) begin
          load_r <= load_r + 1'b1;
        end
      end
      if (state_r == ST_EMIT && emit_take) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ipipe_r[0] <= idx_r[IW-1:0];
    pt_pipe_r[0] <= rd_r;
    for (int s = 1; s <= LAT; s++) begin
      ipipe_r[s] <= ipipe_r[s-1];
    end
    for (int s = 1; s < LAT; s++) begin
      pt_pipe_r[s] <= pt_pipe_r[s-1];
    end
    if (acc && in_data.last_point) begin
      n_r <= (load_r < CW'(POINTS)) ? load_r + 1'b1 : load_r;
      sk_r <= '0;
      pass_r <= '0;
      conv_r <= 1'b0;
    end
    unique case (state_r)
      ST_SEED: begin
        sk_r <= sk_r + 1'b1;
        if (sk_r != 2'd0) begin
          cen_r[sk_r-1'b1] <= rd_r;
        end
        idx_r <= '0;
      end
      ST_SEEDW: begin
        cen_r[2] <= rd_r;
        idx_r <= '0;
        for (int k = 0; k < NCLU; k++) begin
          cnt_r[k] <= '0;
          for (int f = 0; f < NFEAT; f++) sum_r[k][f] <= '0;
        end
      end
      ST_ASSIGN: idx_r <= idx_r + 1'b1;
      default: ;
    endcase
    if (vpipe_r[LAT]) begin
      cnt_r[label] <= cnt_r[label] + 1'b1;
      for (int f = 0; f < NFEAT; f++) begin
        sum_r[label][f] <= sum_r[label][f] +
          SW'(pt_pipe_r[LAT-1][(NFEAT-1-f)*FEATURE_BITS +: FEATURE_BITS]);
      end
    end
    if (state_r == ST_DRAIN && state_nxt == ST_DIV) begin
      dj_r <= '0;
      same_r <= 1'b1;
    end
    if (state_r == ST_DIVW && !div_busy) begin
      if (cnt_r[dj_r[3:2]] != '0) begin
        if (quo[FEATURE_BITS-1:0] !=
            cen_r[dj_r[3:2]][(NFEAT-1-dj_r[1:0])*FEATURE_BITS +: FEATURE_BITS]) begin
          same_r <= 1'b0;
        end
        cen_r[dj_r[3:2]][(NFEAT-1-dj_r[1:0])*FEATURE_BITS +: FEATURE_BITS] <=
          quo[FEATURE_BITS-1:0];
      end
      dj_r <= dj_r + 1'b1;
    end
    if (state_r == ST_CHECK) begin
      pass_r <= pass_r + 1'b1;
      conv_r <= same_r;
      idx_r <= '0;
      for (int k = 0; k < NCLU; k++) begin
        cnt_r[k] <= '0;
        for (int f = 0; f < NFEAT; f++) sum_r[k][f] <= '0;
      end
    end
    if (state_r == ST_EMIT && emit_take) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && emit_take) begin
      odata_r.point_index <= 6'(idx_r);
      odata_r.cluster <= lab_mem[idx_r[IW-1:0]];
      odata_r.passes_done <= pass_r;
      odata_r.converged <= conv_r;
      odata_r.final_label <= (idx_r + 1'b1 == n_r);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data = odata_r;

  logic [7:0] lim;
  assign lim = (limit_r == 8'd0) ? 8'd1 : limit_r;
  assign div_start = (state_r == ST_DIV);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (acc && in_data.last_point) state_nxt = ST_SEED;
      ST_SEED: if (sk_r == 2'd2) state_nxt = ST_SEEDW;
      ST_SEEDW: state_nxt = ST_ASSIGN;
      ST_ASSIGN: if (idx_r + 1'b1 == n_r) state_nxt = ST_DRAIN;
      ST_DRAIN: if (vpipe_r == '0) state_nxt = ST_DIV;
      ST_DIV: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (!div_busy) begin
          state_nxt = (dj_r == 4'd11) ? ST_CHECK : ST_DIV;
        end
      end
      ST_CHECK: begin
        state_nxt = (same_r || pass_r + 1'b1 >= lim) ? ST_EMIT : ST_ASSIGN;
      end
      ST_EMIT: if (emit_take && idx_r + 1'b1 == n_r) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> in_stall) else $error("input taken during run");
  a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
    load_r <= CW'(POINTS)) else $error("load count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// File: dv/kmeans_three_cluster_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_three_cluster_top_tb
// Self-checking bench for the three-cluster k-means block.
// ----------------------------------------------------------------------------
// Point sets are streamed in bursts, clustered by an in-bench Lloyd model and
// every label item is checked field by field. Several metric, seed and limit
// settings are visited, with random stalls on the label side.
module kmeans_three_cluster_top_tb;
  import kmc_pkg::*;

  localparam int NPTS = 64;
  localparam int WATCH_LIMIT = 500000;
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  kmeans_three_cluster_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block state and registers.
  logic [15:0] pt_mem [NPTS][NFEAT];
  int unsigned n_loaded;
  logic [1:0] m_metric = METRIC_EUCLID;
  logic [5:0] m_seed [NCLU] = '{6'd0, 6'd1, 6'd2};
  logic [7:0] m_limit = 8'd20;

  in_item_t point_q[$];
  out_item_t label_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [67:0] point_dist(int p, logic [15:0] c [NFEAT]);
    logic [67:0] acc;
    logic [31:0] a2, b2, d;
    logic [63:0] sq;
    acc = '0;
    for (int f = 0; f < NFEAT; f++) begin
      if (m_metric == METRIC_EUCLID) begin
        d = (pt_mem[p][f] > c[f]) ? pt_mem[p][f] - c[f] : c[f] - pt_mem[p][f];
        sq = 64'(d) * 64'(d);
        acc += 68'(sq);
      end else if (m_metric == METRIC_SQDIFF) begin
        a2 = 32'(pt_mem[p][f]) * 32'(pt_mem[p][f]);
        b2 = 32'(c[f]) * 32'(c[f]);
        d = (a2 > b2) ? a2 - b2 : b2 - a2;
        sq = 64'(d) * 64'(d);
        acc += 68'(sq);
      end else begin
        d = (pt_mem[p][f] > c[f]) ? pt_mem[p][f] - c[f] : c[f] - pt_mem[p][f];
        acc += 68'(d);
      end
    end
    return acc;
  endfunction

  task automatic label_set(in_item_t it);
    logic [15:0] cent [NCLU][NFEAT];
    logic [15:0] mean;
    logic [67:0] best, dd;
    logic [1:0] lab [NPTS];
    int unsigned sums [NCLU][NFEAT];
    int unsigned cnt [NCLU];
    int unsigned n, lim, passes, s;
    bit conv, same;
    out_item_t r;
    if (n_loaded < NPTS) begin
      pt_mem[n_loaded] = '{it.sepal_length, it.sepal_width, it.petal_length,
                           it.petal_width};
      n_loaded++;
    end
    if (!it.last_point) return;
    n = n_loaded;
    for (int k = 0; k < NCLU; k++) begin
      s = (m_seed[k] >= n) ? n - 1 : m_seed[k];
      cent[k] = pt_mem[s];
    end
    lim = (m_limit == 0) ? 1 : m_limit;
    passes = 0;
    conv = 1'b0;
    while (passes < lim) begin
      for (int k = 0; k < NCLU; k++) begin
        cnt[k] = 0;
        for (int f = 0; f < NFEAT; f++) sums[k][f] = 0;
      end
      for (int i = 0; i < n; i++) begin
        best = point_dist(i, cent[0]);
        lab[i] = 2'd0;
        for (int k = 1; k < NCLU; k++) begin
          dd = point_dist(i, cent[k]);
          if (dd < best) begin
            best = dd;
            lab[i] = 2'(k);
          end
        end
        for (int f = 0; f < NFEAT; f++) sums[lab[i]][f] += pt_mem[i][f];
        cnt[lab[i]]++;
      end
      same = 1'b1;
      for (int k = 0; k < NCLU; k++) begin
        if (cnt[k] != 0) begin
          for (int f = 0; f < NFEAT; f++) begin
            mean = 16'(sums[k][f] / cnt[k]);
            if (mean != cent[k][f]) same = 1'b0;
            cent[k][f] = mean;
          end
        end
      end
      passes++;
      if (same) begin
        conv = 1'b1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.point_index = 6'(i);
      r.cluster = lab[i];
      r.passes_done = 8'(passes);
      r.converged = conv;
      r.final_label = (i + 1 == n);
      label_q = {label_q, r};
    end
    n_loaded = 0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) label_set(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (point_q.size() > 0) begin
          in_data <= point_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall pattern, one long hold while the sender is blocked.
  int hold_left = 0;
  bit long_done = 1'b0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (label_q.size() == 0) begin
        report("unexpected item", 0, 0);
      end else begin
        if (out_data.point_index != label_q[0].point_index)
          report("point_index", 32'(out_data.point_index), 32'(label_q[0].point_index));
        if (out_data.cluster != label_q[0].cluster)
          report("cluster", 32'(out_data.cluster), 32'(label_q[0].cluster));
        if (out_data.passes_done != label_q[0].passes_done)
          report("passes_done", 32'(out_data.passes_done), 32'(label_q[0].passes_done));
        if (out_data.converged != label_q[0].converged)
          report("converged", 32'(out_data.converged), 32'(label_q[0].converged));
        if (out_data.final_label != label_q[0].final_label)
          report("final_label", 32'(out_data.final_label), 32'(label_q[0].final_label));
        void'(label_q.pop_front());
      end
    end
    if (!long_done && out_valid && in_valid) begin
      long_done = 1'b1;
      hold_left = 3000;
    end
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("kmeans_three_cluster_top test failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_METRIC: m_metric = val[1:0];
      CFG_SEED0: m_seed[0] = val[5:0];
      CFG_SEED1: m_seed[1] = val[5:0];
      CFG_SEED2: m_seed[2] = val[5:0];
      CFG_LIMIT: m_limit = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pt(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                         logic [15:0] d, bit last);
    in_item_t it;
    it.sepal_length = a;
    it.sepal_width = b;
    it.petal_length = c;
    it.petal_width = d;
    it.last_point = last;
    point_q = {point_q, it};
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (point_q.size() > 0 || in_valid || label_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random set: points spread around three random centers, or pure noise.
  task automatic rand_set(int n);
    logic [15:0] ctr [NCLU][NFEAT];
    int k, spread;
    bit noise;
    noise = ($urandom_range(0, 4) == 0);
    spread = 1 << $urandom_range(4, 13);
    for (int j = 0; j < NCLU; j++)
      for (int f = 0; f < NFEAT; f++) ctr[j][f] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 2);
      if (noise)
        send_pt(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
      else
        send_pt(ctr[k][0] ^ 16'($urandom_range(0, spread)),
                ctr[k][1] ^ 16'($urandom_range(0, spread)),
                ctr[k][2] ^ 16'($urandom_range(0, spread)),
                ctr[k][3] ^ 16'($urandom_range(0, spread)), i == n - 1);
    end
  endtask

  // Sets of one phase follow each other without waiting for their labels.
  task automatic rand_phase(int items);
    int n;
    while (items > 0) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
      rand_set(n);
      items -= n;
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with reset settings: extremes, tiny sets, equal points.
    send_pt(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pt(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pt(16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 1'b0);
    send_pt(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    wait_drained();
    send_pt(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1);
    wait_drained();
    send_pt(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0);
    send_pt(16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b1);
    wait_drained();

    cfg_write(CFG_METRIC, 8'hFD);
    cfg_write(CFG_SEED0, 8'd63);
    cfg_write(CFG_SEED1, 8'd63);
    cfg_write(CFG_SEED2, 8'd0);
    cfg_write(CFG_LIMIT, 8'd0);
    cfg_write(CFG_SPARE_LO, 8'hAA);
    cfg_write(CFG_SPARE_HI, 8'h55);
    send_pt(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pt(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pt(16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b1);
    wait_drained();

    // Full store, then overflow points that are dropped.
    cfg_write(CFG_METRIC, 8'd1);
    cfg_write(CFG_LIMIT, 8'd255);
    rand_set(64);
    wait_drained();
    cfg_write(CFG_METRIC, 8'd3);
    cfg_write(CFG_LIMIT, 8'd6);
    rand_set(70);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(CFG_METRIC, 8'($urandom_range(0, 3)) | 8'($urandom) & 8'hFC);
      cfg_write(CFG_SEED0, 8'($urandom_range(0, 7)));
      cfg_write(CFG_SEED1, 8'($urandom_range(0, 7)));
      cfg_write(CFG_SEED2, (ph == 3) ? 8'hFF : 8'($urandom_range(0, 20)));
      cfg_write(CFG_LIMIT, (ph == 1) ? 8'd1 : (ph == 4) ? 8'd255 : 8'($urandom_range(1, 30)));
      rand_phase(50);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("kmeans_three_cluster_top test passed");
    end else begin
      $display("kmeans_three_cluster_top test failed");
    end
    $finish;
  end
endmodule
